// ===== src/packet_counter_checker_resync_unit_macros.svh =====
// Assertion macros for the packet counter checker resync unit.
// Used by the port checker; no other dependencies.
`ifndef PACKET_COUNTER_CHECKER_RESYNC_UNIT_MACROS_SVH
`define PACKET_COUNTER_CHECKER_RESYNC_UNIT_MACROS_SVH
// implication checked on every rising edge outside reset
`define PCCR_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("pccr check failed");
// next-cycle implication
`define PCCR_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("pccr check failed");
`endif

// ===== src/pccr_pkg.sv =====
// Shared types and constants of the packet counter checker resync unit.
// No dependencies.
package pccr_pkg;
    localparam int MaxFrames       = 8;
    localparam int MaxFrameSamples = 256;
    localparam int StoreDepth      = MaxFrames * MaxFrameSamples;
    localparam int AddrW           = $clog2(StoreDepth);
    localparam int CntW            = AddrW + 1;

    localparam logic [1:0] OP_CHECK   = 2'd0;
    localparam logic [1:0] OP_LOAD    = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    localparam logic [2:0] CFG_FIRST   = 3'd0;
    localparam logic [2:0] CFG_ACQ     = 3'd1;
    localparam logic [2:0] CFG_STEP    = 3'd2;
    localparam logic [2:0] CFG_EVERY   = 3'd3;
    localparam logic [2:0] CFG_BYTES   = 3'd4;
    localparam logic [2:0] CFG_FRAMES  = 3'd5;

    typedef struct packed {
        logic do_check;
        logic do_store;
        logic do_restart;
        logic sync_init;
        logic pos_load;
        logic rd_issue;
        logic cmp_eval;
        logic fin_ok;
        logic fin_fail;
    } t_cmd;

    typedef struct packed {
        logic pos_done;
        logic cand_done;
        logic cand_ok;
    } t_stat;

    function automatic logic [63:0] byte_mask(input logic [3:0] b);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            if (b > 4'(i)) m[i*8 +: 8] = 8'hFF;
        end
        return m;
    endfunction
endpackage

// ===== src/pccr_ctrl.sv =====
// Controller state machine of the packet counter checker resync unit.
// Depends on pccr_pkg.
module pccr_ctrl import pccr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [1:0] i_op,
    input  logic       i_last,
    input  t_stat      i_stat,
    output t_cmd       o_cmd,
    output logic       o_busy
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_POS  = 5'b00010,
        S_RD   = 5'b00100,
        S_WAIT = 5'b01000,
        S_CMP  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   acc;

    assign acc    = i_start && (r_state == S_IDLE);
    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.do_check   = (i_op == OP_CHECK);
                    o_cmd.do_store   = (i_op == OP_LOAD);
                    o_cmd.do_restart = (i_op == OP_RESTART);
                    if (i_op == OP_LOAD && i_last) begin
                        o_cmd.sync_init = 1'b1;
                        n_state = S_POS;
                    end
                end
            end
            S_POS: begin
                if (i_stat.pos_done) begin
                    o_cmd.fin_fail = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.pos_load = 1'b1;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd_issue = 1'b1;
                n_state = S_WAIT;
            end
            S_WAIT: n_state = S_CMP;
            S_CMP: begin
                if (i_stat.cand_ok) begin
                    o_cmd.fin_ok = 1'b1;
                    n_state = S_IDLE;
                end else if (i_stat.cand_done) begin
                    o_cmd.cmp_eval = 1'b1;
                    n_state = S_POS;
                end else begin
                    o_cmd.cmp_eval = 1'b1;
                    n_state = S_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (!acc && r_state == S_IDLE) o_cmd = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end
endmodule

// ===== src/pccr_dp.sv =====
// Datapath of the packet counter checker resync unit: config, counters,
// frame store and sync search. Depends on pccr_pkg.
module pccr_dp import pccr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic [63:0] i_sample,
    input  logic [8:0]  i_frame_len,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    output logic        o_valid,
    output logic        o_ok,
    output logic        o_write,
    output logic [8:0]  o_sync_pos,
    output logic        o_from_sync
);
    logic [63:0] r_first, r_acq_from;
    logic [31:0] r_step, r_every;
    logic [3:0]  r_bytes, r_frames;
    logic [63:0] r_exp, r_next, r_acq;
    logic [CntW-1:0] r_load;
    logic [63:0] r_mem [StoreDepth];
    logic [63:0] r_rd, r_word0;

    logic [8:0]  r_flen, r_pos;
    logic [3:0]  r_nf, r_j, r_cnt;
    logic [63:0] r_want;
    logic [AddrW:0] r_at;
    logic        r_rd_cand;
    logic [63:0] mask;

    assign mask = byte_mask(r_bytes);

    // combinational helpers
    logic        chk_ok, chk_due;
    logic        gate_hit;
    logic [8:0]  flen_c;
    logic [3:0]  nf_c;
    logic [63:0] cand_c, exp_sync, seen;

    assign chk_due = (r_exp == r_next);
    assign chk_ok  = !chk_due || (((r_exp ^ i_sample) & mask) == '0);
    assign flen_c  = (i_frame_len > 9'(MaxFrameSamples)) ? 9'(MaxFrameSamples) : i_frame_len;
    assign nf_c    = (r_frames > 4'(MaxFrames)) ? 4'(MaxFrames) : r_frames;
    assign cand_c  = r_rd & mask;
    assign seen    = i_cmd.do_check ? i_sample : r_word0;
    assign gate_hit = (((seen ^ r_acq) & mask) == '0);
    assign exp_sync = r_want + 64'(r_step);

    // candidate stage: when r_rd_cand, r_rd is position word
    logic match_c, done_c, ok_c;
    logic [3:0] cnt_n;
    always_comb begin
        match_c = 1'b0;
        cnt_n   = r_cnt;
        if (!r_rd_cand) begin
            match_c = !r_at[AddrW] && (((r_want ^ r_rd) & mask) == '0);
            if (match_c) cnt_n = r_cnt + 4'd1;
        end
        ok_c   = (cnt_n >= r_nf);
        done_c = !r_rd_cand && !match_c;
    end
    assign o_stat.pos_done  = (r_pos >= r_flen);
    assign o_stat.cand_ok   = ok_c;
    assign o_stat.cand_done = done_c || (r_j >= r_nf);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 64'd1; r_acq_from <= 64'd1; r_step <= 32'd1; r_every <= 32'd1;
            r_bytes <= 4'd8;  r_frames <= 4'd2;
            r_exp <= 64'd1; r_next <= 64'd1; r_acq <= 64'd1;
            r_load <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_FIRST:  r_first    <= i_cfg_data;
                    CFG_ACQ:    r_acq_from <= i_cfg_data;
                    CFG_STEP:   r_step     <= i_cfg_data[31:0];
                    CFG_EVERY:  r_every    <= i_cfg_data[31:0];
                    CFG_BYTES:  r_bytes    <= i_cfg_data[3:0];
                    CFG_FRAMES: r_frames   <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (i_cmd.do_restart) begin
                r_exp <= r_first; r_next <= r_first; r_acq <= r_acq_from; r_load <= '0;
            end
            if (i_cmd.do_store) begin
                if (r_load < CntW'(StoreDepth)) r_load <= r_load + 1'b1;
            end
            if (i_cmd.sync_init) r_load <= '0;
            if (i_cmd.do_check) begin
                o_valid <= 1'b1; o_ok <= chk_ok; o_write <= 1'b1;
                o_sync_pos <= '0; o_from_sync <= 1'b0;
                if (chk_ok) begin
                    r_next <= r_exp + 64'(r_every);
                    r_exp  <= r_exp + 64'(r_step);
                    if (r_acq != '0) begin
                        if (!gate_hit) begin
                            r_next <= r_exp + 64'(r_step); o_write <= 1'b0;
                        end else r_acq <= '0;
                    end
                end
            end
            if (i_cmd.fin_fail) begin
                o_valid <= 1'b1; o_ok <= 1'b0; o_write <= 1'b1;
                o_sync_pos <= r_flen; o_from_sync <= 1'b1;
            end
            if (i_cmd.fin_ok) begin
                o_valid <= 1'b1; o_ok <= 1'b1; o_write <= 1'b1;
                o_sync_pos <= r_pos; o_from_sync <= 1'b1;
                r_exp  <= exp_sync;
                r_next <= r_want + 64'(r_every);
                if (r_acq != '0) begin
                    if (!gate_hit) begin
                        r_next <= exp_sync; o_write <= 1'b0;
                    end else r_acq <= '0;
                end
            end
        end
    end

    // frame store
    logic [AddrW-1:0] rd_addr;
    assign rd_addr = r_rd_cand ? AddrW'(r_pos) : r_at[AddrW-1:0];
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_store && r_load < CntW'(StoreDepth))
            r_mem[r_load[AddrW-1:0]] <= i_sample;
        if (i_cmd.rd_issue) r_rd <= r_mem[rd_addr];
    end

    // search registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_store && r_load == '0) r_word0 <= i_sample;
        if (i_cmd.sync_init) begin
            r_flen <= flen_c; r_pos <= '0; r_nf <= nf_c;
        end
        if (i_cmd.pos_load) begin
            r_rd_cand <= 1'b1; r_cnt <= 4'd1; r_j <= 4'd1;
            r_at  <= (AddrW+1)'(r_flen) + (AddrW+1)'(r_pos);
        end
        if (i_cmd.cmp_eval) begin
            if (r_rd_cand) begin
                r_rd_cand <= 1'b0;
                r_want <= cand_c + 64'(r_step);
                if (r_j >= r_nf) r_pos <= r_pos + 9'd1;
            end else if (done_c || r_j >= r_nf) begin
                r_pos <= r_pos + 9'd1;
            end else begin
                r_cnt <= cnt_n; r_j <= r_j + 4'd1;
                r_at  <= r_at + (AddrW+1)'(r_flen);
                r_want <= r_want + 64'(r_step);
            end
        end
    end
endmodule

// ===== src/packet_counter_checker_resync_unit.sv =====
// Top level of the packet counter checker resync unit.
// Depends on pccr_pkg, pccr_ctrl and pccr_dp.
//
// Usage: drive i_op/i_sample/i_last/i_frame_len with start; an item is
// taken when start is high and busy is low. Checks, plain loads and
// restarts leave busy low, so a new item may follow every cycle. A check
// gives its result in the cycle after acceptance on the o_ fields, marked by
// o_valid for one cycle. A load with i_last starts the sync search: per
// position a position step, then per word read a read, wait and compare
// step; busy stays high until the result strobe. Configuration writes
// use i_cfg_valid/o_cfg_ready with i_cfg_index and i_cfg_data and are taken
// in any cycle; write them only while no item is in flight.
// Synchronous active-low reset restores the config, counters, controller
// state and o_valid; the other output and search registers are not reset,
// and the frame store needs no clearing. The receiver cannot stall.
module packet_counter_checker_resync_unit import pccr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_op,
    input  logic [63:0] i_sample,
    input  logic        i_last,
    input  logic [8:0]  i_frame_len,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    output logic        o_valid,
    output logic        o_ok,
    output logic        o_write,
    output logic [8:0]  o_sync_pos,
    output logic        o_from_sync
);
    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    pccr_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_start(start), .i_op, .i_last,
        .i_stat(stat), .o_cmd(cmd), .o_busy(busy)
    );

    pccr_dp u_dp (
        .i_clk, .i_rst_n, .i_cfg_valid, .i_cfg_index, .i_cfg_data,
        .i_sample, .i_frame_len, .i_cmd(cmd), .o_stat(stat),
        .o_valid, .o_ok, .o_write, .o_sync_pos, .o_from_sync
    );
endmodule

// ===== src/pccr_checker.sv =====
// Port checker for the packet counter checker resync unit, bound to the top.
// Depends on pccr_pkg and packet_counter_checker_resync_unit_macros.svh.
`include "packet_counter_checker_resync_unit_macros.svh"
module pccr_checker import pccr_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] i_op,
    input logic       i_last,
    input logic       o_valid,
    input logic       o_from_sync,
    input logic [8:0] o_sync_pos
);
    `PCCR_ASSERT_NXT(a_chk_res, i_clk, i_rst_n, start && !busy && i_op == OP_CHECK, o_valid && !o_from_sync)
    `PCCR_ASSERT_NXT(a_sync_busy, i_clk, i_rst_n, start && !busy && i_op == OP_LOAD && i_last, busy && !o_valid)
    `PCCR_ASSERT_IMP(a_chk_pos, i_clk, i_rst_n, o_valid && !o_from_sync, o_sync_pos == 9'd0)
    `PCCR_ASSERT_IMP(a_sync_end, i_clk, i_rst_n, o_valid && o_from_sync, !busy)
endmodule

bind packet_counter_checker_resync_unit pccr_checker u_pccr_checker (
    .i_clk, .i_rst_n, .start, .busy, .i_op, .i_last, .o_valid, .o_from_sync, .o_sync_pos
);
